### hw/rtl/lms_pkg.sv
// lms_pkg: shared types and widths for the list median selector
// no dependencies; imported by the interfaces, the cell and the top level

package lms_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MED_W    = 33;
	localparam int COUNT_W  = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MED_W-1:0]    median_t;
	typedef logic [COUNT_W-1:0]         count_t;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic ins;   // insert the current sample in sorted order
		logic shl;   // move every value one cell toward cell 0
		logic clr;   // drop all held values
	} cell_cmd_t;

endpackage

### hw/rtl/lms_if.sv
// lms_in_if / lms_out_if: valid-ready channels of the list median selector
// depends on lms_pkg for the payload types

interface lms_in_if
	import lms_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface lms_out_if
	import lms_pkg::*;
();
	logic    valid;
	logic    ready;
	median_t median_doubled;
	count_t  count;
	logic    status;

	modport source (output valid, output median_doubled, output count, output status,
		input ready);
	modport sink   (input valid, input median_doubled, input count, input status,
		output ready);
endinterface

### hw/rtl/lms_cell.sv
// lms_cell: one slot of the sorted insertion chain
// depends on lms_pkg; instantiated in a row by list_median_select

module lms_cell
	import lms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  sample_t   sample,
	input  logic      left_valid,
	input  logic      left_gt,
	input  sample_t   left_val,
	input  sample_t   right_val,
	output logic      valid,
	output logic      gt,
	output sample_t   val
);

	logic    valid_q;
	sample_t val_q;

	// empty slots count as greater so the new sample lands at the end
	assign gt    = !valid_q || (val_q > sample);
	assign valid = valid_q;
	assign val   = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			val_q <= left_gt ? left_val : sample;
		end else if (cmd.shl) begin
			val_q <= right_val;
		end
	end

endmodule

### hw/rtl/list_median_select.sv
// list_median_select: top level, insertion chain of lms_cell plus control
// depends on lms_pkg, lms_if (lms_in_if, lms_out_if) and lms_cell
//
// usage
//   samples: one item per list element (sample, last); the list ends on last = 1
//   results: one item per list (median_doubled, count, status)
//   every accepted sample is placed in sorted order in a row of MAX_ITEMS
//   cells in the cycle it is taken, so within a list one item per cycle
//   after the item marked last, the chain shifts toward cell 0 until the
//   middle value(s) sit in cells 0 and 1; the result register is then
//   loaded from those cells
//   samples.ready is low from the last item until the result is loaded
//   a list longer than MAX_ITEMS keeps the first MAX_ITEMS, status = 1
//   a stalled receiver holds the result register; a following list is
//   still taken, and its own result waits until the register is free
//   reset (arst_n low) empties the chain and drops any pending result

module list_median_select
	import lms_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lms_in_if.sink    samples,
	lms_out_if.source results
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int HI_IDX = (MAX_ITEMS > 1) ? 1 : 0;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_SHIFT  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] shift_q;
	logic             ovf_q;

	logic             out_valid_q;
	median_t          median_q;
	count_t           count_out_q;
	logic             status_q;

	logic             accept;
	logic             full;
	logic [CNT_W-1:0] n_new;
	logic             load_out;
	cell_cmd_t        cmd;

	logic    cell_valid [MAX_ITEMS];
	logic    cell_gt    [MAX_ITEMS];
	sample_t cell_val   [MAX_ITEMS];

	assign samples.ready = (state_q == ST_ACCEPT);
	assign accept        = samples.valid && samples.ready;
	assign full          = (count_q == CNT_W'(MAX_ITEMS));
	// kept count once this item is placed (dropped when the chain is full)
	assign n_new         = full ? count_q : count_q + 1'b1;
	// result register frees when empty or taken this cycle
	assign load_out      = (state_q == ST_FINISH) && (!out_valid_q || results.ready);

	always_comb begin
		cmd.ins = accept && !full;
		cmd.shl = (state_q == ST_SHIFT) && (shift_q != '0);
		cmd.clr = load_out;
	end

	// insertion chain: cell 0 sees a full, never-greater neighbor on its left
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic    lv;
		logic    lg;
		sample_t lval;
		sample_t rval;

		if (i == 0) begin : g_first
			assign lv   = 1'b1;
			assign lg   = 1'b0;
			assign lval = samples.sample;
		end else begin : g_mid
			assign lv   = cell_valid[i-1];
			assign lg   = cell_gt[i-1];
			assign lval = cell_val[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_end
			assign rval = cell_val[i];
		end else begin : g_inner
			assign rval = cell_val[i+1];
		end

		lms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.sample     (samples.sample),
			.left_valid (lv),
			.left_gt    (lg),
			.left_val   (lval),
			.right_val  (rval),
			.valid      (cell_valid[i]),
			.gt         (cell_gt[i]),
			.val        (cell_val[i])
		);
	end

	// list control: collect, shift the middle down, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			count_q <= '0;
			shift_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (samples.last) begin
							// odd n: middle at (n-1)/2; even n: lower middle there too
							shift_q <= (n_new - 1'b1) >> 1;
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						shift_q <= shift_q - 1'b1;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_ACCEPT;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			// odd count doubles the middle, even count adds the two middles
			median_q    <= {cell_val[0][SAMPLE_W-1], cell_val[0]} +
				(count_q[0] ? {cell_val[0][SAMPLE_W-1], cell_val[0]}
				            : {cell_val[HI_IDX][SAMPLE_W-1], cell_val[HI_IDX]});
			count_out_q <= COUNT_W'(count_q);
			status_q    <= ovf_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.median_doubled = median_q;
	assign results.count          = count_out_q;
	assign results.status         = status_q;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for list_median_select, scoreboard class plus driver tasks
// depends on lms_pkg, lms_if (lms_in_if, lms_out_if) and the list_median_select rtl

module tb;
	import lms_pkg::*;

	localparam int CAP        = 64;    // MAX_ITEMS of the instance under test
	localparam int ITEM_GOAL  = 1700;  // random items to send
	localparam int QUIET_MAX  = 3000;  // cycles with no handshake before giving up
	localparam int TAIL_WAIT  = 40;    // wait after the last result before the final check

	localparam sample_t TOP_S  = sample_t'(32'h7FFF_FFFF);
	localparam sample_t BOT_S  = sample_t'(32'h8000_0000);
	localparam sample_t ONE_S  = sample_t'(32'h0001_0000);  // 1.0 in Q16.16

	// one expected median result
	typedef struct {
		median_t doubled;
		count_t  kept;
		logic    dropped;
	} median_result_t;

	// keeps a sorted copy of the current list and queues the medians it implies
	class median_board;
		sample_t        kept_sorted[$];
		logic           overflowed;
		median_result_t awaited_medians[$];
		int             errors;

		function new();
			overflowed = 1'b0;
			errors     = 0;
		endfunction

		task report(input string what);
			$display("ERROR at %0t ns: %s", $time, what);
			errors++;
		endtask

		// accepted sample: insert in order, or drop when full; close the list on last
		task note_sample(input sample_t s, input logic is_last);
			int pos;
			int n;
			median_result_t r;
			if (kept_sorted.size() < CAP) begin
				pos = kept_sorted.size();
				for (int i = 0; i < kept_sorted.size(); i++) begin
					if (kept_sorted[i] > s) begin
						pos = i;
						break;
					end
				end
				kept_sorted.insert(pos, s);
			end else begin
				overflowed = 1'b1;
			end
			if (is_last) begin
				n = kept_sorted.size();
				if (n % 2 == 1)
					r.doubled = median_t'(kept_sorted[n/2]) + median_t'(kept_sorted[n/2]);
				else
					r.doubled = median_t'(kept_sorted[n/2-1]) + median_t'(kept_sorted[n/2]);
				r.kept    = count_t'(n);
				r.dropped = overflowed;
				awaited_medians.push_back(r);
				kept_sorted.delete();
				overflowed = 1'b0;
			end
		endtask

		task check_result(input median_t md, input count_t cnt, input logic st);
			median_result_t r;
			if (awaited_medians.size() == 0) begin
				report($sformatf("unexpected result median_doubled=%0d count=%0d status=%0b",
					md, cnt, st));
			end else begin
				r = awaited_medians.pop_front();
				if (md !== r.doubled)
					report($sformatf("median_doubled %0d, expected %0d", md, r.doubled));
				if (cnt !== r.kept)
					report($sformatf("count %0d, expected %0d", cnt, r.kept));
				if (st !== r.dropped)
					report($sformatf("status %0b, expected %0b", st, r.dropped));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	lms_in_if  samples_if();
	lms_out_if results_if();

	list_median_select #(
		.MAX_ITEMS(CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	median_board board;
	bit          calm;         // no idling on either side while set
	int          items_sent;
	int unsigned quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// every input known from time zero
	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.sample = '0;
		samples_if.last   = 1'b0;
		results_if.ready  = 1'b0;
		board             = new();
		calm              = 1'b0;
		items_sent        = 0;
	end

	// receiver: stalls in about a third of the cycles unless calm
	always @(posedge clk)
		results_if.ready <= arst_n && (calm || $urandom_range(99) >= 35);

	// monitors sample at the edge, before any driver update lands
	always @(posedge clk) begin
		if (samples_if.valid && samples_if.ready)
			board.note_sample(samples_if.sample, samples_if.last);
		if (results_if.valid && results_if.ready)
			board.check_result(results_if.median_doubled, results_if.count, results_if.status);
	end

	// watchdog: counts cycles in which no item moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready) ||
				(results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			board.report($sformatf("no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, board.awaited_medians.size()));
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one item, idling at random first; valid stays high on return so
	// back-to-back items never lower and raise it in the same step
	task automatic send_item(input sample_t s, input logic is_last);
		while (!calm && $urandom_range(99) < 35) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.sample <= s;
		samples_if.last   <= is_last;
		do
			@(posedge clk);
		while (!samples_if.ready);
	endtask

	// stop sending and hold off until every expected median has come back;
	// the extra edge lets the monitor log the item just accepted
	task automatic drain_results();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (board.awaited_medians.size() != 0)
			@(posedge clk);
	endtask

	// sample mix: full range, extremes, near the rails, and a narrow band that
	// makes equal values common
	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			4: begin
				case ($urandom_range(4))
					0: return TOP_S;
					1: return BOT_S;
					2: return '0;
					3: return sample_t'(-1);
					default: return ONE_S;
				endcase
			end
			5, 6: return sample_t'(int'($urandom_range(16)) - 8);
			7: return TOP_S - sample_t'($urandom_range(3));
			8: return BOT_S + sample_t'($urandom_range(3));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_random_list(input int len);
		for (int i = 0; i < len; i++) begin
			send_item(pick_sample(), i == len - 1);
			items_sent++;
			calm = (items_sent >= 700 && items_sent < 1000);
		end
	endtask

	initial begin
		int list_len;
		int lists_done;
		lists_done = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lists
		send_item(TOP_S, 1'b1);                              // single element, top
		send_item(BOT_S, 1'b1);                              // single element, bottom
		send_item(TOP_S, 1'b0); send_item(TOP_S, 1'b1);      // largest doubled value
		send_item(BOT_S, 1'b0); send_item(BOT_S, 1'b1);      // smallest doubled value
		send_item(TOP_S, 1'b0); send_item(BOT_S, 1'b1);      // top and bottom rails, sum -1
		send_item(sample_t'(3), 1'b0);                       // odd count, unsorted arrival
		send_item(sample_t'(1), 1'b0);
		send_item(sample_t'(2), 1'b1);
		send_item(ONE_S, 1'b0);                              // even count, repeated values
		send_item(sample_t'(-1), 1'b0);
		send_item(sample_t'(7), 1'b0);
		send_item(sample_t'(-1), 1'b1);
		send_item(sample_t'(5), 1'b0);                       // all equal
		send_item(sample_t'(5), 1'b0);
		send_item(sample_t'(5), 1'b1);
		send_item(sample_t'(0), 1'b0);                       // descending arrival
		send_item(sample_t'(-1), 1'b0);
		send_item(BOT_S, 1'b1);

		// hold-off: sender waits for the directed results before going random
		drain_results();

		// random lists: the first three hit a full store exactly and by overflow,
		// including a dropped element marked last
		while (items_sent < ITEM_GOAL) begin
			case (lists_done)
				0: list_len = CAP;
				1: list_len = CAP + 1;
				2: list_len = CAP + 3;
				default: begin
					case ($urandom_range(99)) inside
						[0:69]:  list_len = $urandom_range(10, 1);
						[70:89]: list_len = $urandom_range(CAP - 1, 11);
						[90:94]: list_len = CAP;
						default: list_len = $urandom_range(CAP + 16, CAP + 1);
					endcase
				end
			endcase
			send_random_list(list_len);
			lists_done++;
			if (lists_done == 40)
				drain_results();
		end

		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (board.awaited_medians.size() != 0)
			board.report($sformatf("%0d results never arrived", board.awaited_medians.size()));
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/lms_pkg.sv
hw/rtl/lms_if.sv
hw/rtl/lms_cell.sv
hw/rtl/list_median_select.sv
bench/tb.sv
